// ===== sv/bpc_pkg.sv =====
package bpc_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_SCA = 3'd0;
  localparam logic [IDX_W-1:0] REG_UCA = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCB = 3'd2;
  localparam logic [IDX_W-1:0] REG_TCM = 3'd3;
  localparam logic [IDX_W-1:0] REG_OSS = 3'd4;

  localparam int DIV_W = 33;
  localparam int DVS_W = 18;

  localparam logic [17:0] PRESS_MAX = 18'h3ffff;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } coef_t;

  // carried through the temperature divider
  typedef struct packed {
    logic signed [18:0] x1;
    logic [18:0]        up;
    logic               neg;
    logic               fault;
  } tside_t;

  // carried through the pressure divider
  typedef struct packed {
    logic signed [15:0] t;
    logic               hi;
    logic               fault;
  } pside_t;

  localparam int SIDE_W  = $bits(tside_t);
  localparam int PSIDE_W = $bits(pside_t);
  localparam int PAD_W   = SIDE_W - PSIDE_W;

  typedef logic [SIDE_W-1:0] side_t;

endpackage

// ===== sv/bpc_div.sv =====
module bpc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bpc_pkg::DIV_W-1:0]   dividend,
  input  logic [bpc_pkg::DVS_W-1:0]   divisor,
  input  bpc_pkg::side_t              side_in,
  output logic                        out_valid,
  output logic [bpc_pkg::DIV_W-1:0]   quotient,
  output bpc_pkg::side_t              side_out
);
  import bpc_pkg::*;

  // one restoring step per stage, quotient bits shift in at the bottom
  logic [DIV_W-1:0] vld;
  logic [DVS_W-1:0] rem  [DIV_W];
  logic [DIV_W-1:0] dq   [DIV_W];
  logic [DVS_W-1:0] dvs  [DIV_W];
  side_t            sd   [DIV_W];

  logic [DVS_W-1:0] rem_next [DIV_W];
  logic [DIV_W-1:0] dq_next  [DIV_W];
  logic [DVS_W:0]   trial    [DIV_W];
  logic [DVS_W:0]   diff     [DIV_W];
  logic [DVS_W-1:0] src_rem  [DIV_W];
  logic [DIV_W-1:0] src_dq   [DIV_W];
  logic [DVS_W-1:0] src_dvs  [DIV_W];

  always_comb begin
    for (int k = 0; k < DIV_W; k++) begin
      if (k == 0) begin
        src_rem[k] = '0;
        src_dq[k]  = dividend;
        src_dvs[k] = divisor;
      end else begin
        src_rem[k] = rem[k-1];
        src_dq[k]  = dq[k-1];
        src_dvs[k] = dvs[k-1];
      end
      trial[k]    = {src_rem[k], src_dq[k][DIV_W-1]};
      diff[k]     = trial[k] - {1'b0, src_dvs[k]};
      rem_next[k] = diff[k][DVS_W] ? trial[k][DVS_W-1:0] : diff[k][DVS_W-1:0];
      dq_next[k]  = {src_dq[k][DIV_W-2:0], ~diff[k][DVS_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_W; k++) begin
        rem[k] <= rem_next[k];
        dq[k]  <= dq_next[k];
        dvs[k] <= src_dvs[k];
        sd[k]  <= (k == 0) ? side_in : sd[k-1];
      end
    end
  end

  assign out_valid = vld[DIV_W-1];
  assign quotient  = dq[DIV_W-1];
  assign side_out  = sd[DIV_W-1];

endmodule

// ===== sv/bpc_tfront.sv =====
module bpc_tfront (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [15:0]                 raw_temp,
  input  logic [18:0]                 raw_pressure,
  input  bpc_pkg::coef_t              coef,
  output logic                        div_valid,
  output logic [bpc_pkg::DIV_W-1:0]   div_dividend,
  output logic [bpc_pkg::DVS_W-1:0]   div_divisor,
  output bpc_pkg::side_t              div_side
);
  import bpc_pkg::*;

  logic [2:0]         vld;
  logic signed [16:0] diff1;
  logic [18:0]        up1, up2, up3;
  logic signed [33:0] prod2;
  logic signed [18:0] x1_3, den3;
  logic signed [16:0] mc_x;
  logic [16:0]        mc_mag;
  logic [18:0]        den_abs;
  tside_t             ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff1 <= $signed({1'b0, raw_temp}) - $signed({1'b0, coef.ac6});
      up1   <= raw_pressure;
      prod2 <= diff1 * $signed({1'b0, coef.ac5});
      up2   <= up1;
      x1_3  <= prod2[33:15];
      den3  <= prod2[33:15] + {{3{coef.md[15]}}, coef.md};
      up3   <= up2;
    end
  end

  assign mc_x    = {coef.mc[15], coef.mc};
  assign mc_mag  = mc_x[16] ? -mc_x : mc_x;
  assign den_abs = den3[18] ? -den3 : den3;

  assign ts.x1    = x1_3;
  assign ts.up    = up3;
  assign ts.neg   = den3[18] ^ coef.mc[15];
  assign ts.fault = (den3 == '0);

  assign div_valid    = vld[2];
  assign div_dividend = {5'd0, mc_mag, 11'd0};
  assign div_divisor  = den_abs[17:0];
  assign div_side     = ts;

endmodule

// ===== sv/bpc_pfront.sv =====
module bpc_pfront (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bpc_pkg::DIV_W-1:0]   div_q,
  input  bpc_pkg::side_t              in_side,
  input  bpc_pkg::coef_t              coef,
  output logic                        div_valid,
  output logic [bpc_pkg::DIV_W-1:0]   div_dividend,
  output logic [bpc_pkg::DVS_W-1:0]   div_divisor,
  output bpc_pkg::side_t              div_side
);
  import bpc_pkg::*;

  tside_t             ts;
  pside_t             ps;
  logic [10:0]        vld;

  logic signed [27:0] x2_c;
  logic signed [28:0] b5_4, b6_5, tsum;
  logic signed [24:0] t25;
  logic signed [15:0] t5, t6, t7, t8, t9, t10, t11, t12, t13, t14;
  logic [18:0]        up4, up5, up6, up7, up8, up9, up10, up11, up12;
  logic               f4, f5, f6, f7, f8, f9, f10, f11, f12, f13, f14;

  logic signed [57:0] sqp6;
  logic signed [44:0] m2_6, m3_6;
  logic [44:0]        sq7;
  logic signed [33:0] x2a7, x2a8, x2a9;
  logic signed [31:0] x1c7, x1c8, x1c9;
  logic signed [39:0] pb2l8, pb1l8;
  logic signed [38:0] pb2h8, pb1h8;
  logic [61:0]        b2sq_c, b1sq_c;
  logic signed [50:0] x1p9;
  logic signed [45:0] x2p9;
  logic [51:0]        sa10;
  logic [46:0]        sb10;
  logic [54:0]        v11, vt;
  logic [31:0]        u11, p_ac4;
  logic [31:0]        b3_12, dp13, b7_14;
  logic [16:0]        b4_12, b4_13, b4_14;
  logic [15:0]        mulc;

  assign ts = tside_t'(in_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:0], in_valid};
    end
  end

  always_comb begin
    x2_c  = ts.neg ? -$signed({1'b0, div_q[26:0]}) : $signed({1'b0, div_q[26:0]});
    tsum  = b5_4 + 29'sd8;
    t25   = tsum[28:4];
    b2sq_c = {pb2h8, 23'd0} + {{22{pb2l8[39]}}, pb2l8};
    b1sq_c = {pb1h8, 23'd0} + {{22{pb1l8[39]}}, pb1l8};
    vt    = v11 + (v11[54] ? 55'd3 : 55'd0);
    p_ac4 = 32'(coef.ac4 * u11);
    mulc  = 16'(17'd50000 >> coef.oss);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature result
      b5_4 <= {{10{ts.x1[18]}}, ts.x1} + {x2_c[27], x2_c};
      up4  <= ts.up;
      f4   <= ts.fault;

      b6_5 <= b5_4 - 29'sd4000;
      if (t25 > 25'sd32767) begin
        t5 <= 16'sh7fff;
      end else if (t25 < -25'sd32768) begin
        t5 <= 16'sh8000;
      end else begin
        t5 <= t25[15:0];
      end
      up5 <= up4;
      f5  <= f4;

      sqp6 <= b6_5 * b6_5;
      m2_6 <= b6_5 * coef.ac2;
      m3_6 <= b6_5 * coef.ac3;
      t6 <= t5; up6 <= up5; f6 <= f5;

      sq7  <= sqp6[56:12];
      x2a7 <= m2_6[44:11];
      x1c7 <= m3_6[44:13];
      t7 <= t6; up7 <= up6; f7 <= f6;

      // split products of the wide square term
      pb2l8 <= coef.b2 * $signed({1'b0, sq7[22:0]});
      pb2h8 <= coef.b2 * $signed({1'b0, sq7[44:23]});
      pb1l8 <= coef.b1 * $signed({1'b0, sq7[22:0]});
      pb1h8 <= coef.b1 * $signed({1'b0, sq7[44:23]});
      x2a8 <= x2a7; x1c8 <= x1c7;
      t8 <= t7; up8 <= up7; f8 <= f7;

      x1p9 <= b2sq_c[61:11];
      x2p9 <= b1sq_c[61:16];
      x2a9 <= x2a8; x1c9 <= x1c8;
      t9 <= t8; up9 <= up8; f9 <= f8;

      sa10 <= {{34{coef.ac1[15]}}, coef.ac1, 2'b00} + {x1p9[50], x1p9}
              + {{18{x2a9[33]}}, x2a9};
      sb10 <= {{15{x1c9[31]}}, x1c9} + {x2p9[45], x2p9} + 47'd2;
      t10 <= t9; up10 <= up9; f10 <= f9;

      v11 <= ({{3{sa10[51]}}, sa10} << coef.oss) + 55'd2;
      u11 <= sb10[33:2] + 32'd32768;
      t11 <= t10; up11 <= up10; f11 <= f10;

      b3_12 <= vt[33:2];
      b4_12 <= p_ac4[31:15];
      t12 <= t11; up12 <= up11; f12 <= f11;

      dp13  <= {13'd0, up12} - b3_12;
      b4_13 <= b4_12;
      f13   <= f12 | (b4_12 == '0);
      t13   <= t12;

      b7_14 <= 32'(dp13 * mulc);
      b4_14 <= b4_13;
      f14   <= f13;
      t14   <= t13;
    end
  end

  assign ps.t     = t14;
  assign ps.hi    = b7_14[31];
  assign ps.fault = f14;

  assign div_valid    = vld[10];
  assign div_dividend = b7_14[31] ? {1'b0, b7_14} : {b7_14, 1'b0};
  assign div_divisor  = {1'b0, b4_14};
  assign div_side     = {{PAD_W{1'b0}}, ps};

endmodule

// ===== sv/bpc_pback.sv =====
module bpc_pback (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bpc_pkg::DIV_W-1:0]   div_q,
  input  bpc_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic signed [15:0]          temperature,
  output logic [17:0]                 pressure,
  output logic                        div_fault
);
  import bpc_pkg::*;

  pside_t             ps;
  logic [2:0]         vld;
  logic [31:0]        p32;
  logic [17:0]        p15, p16, p17;
  logic               big15, big16, big17;
  logic               f15, f16, f17;
  logic signed [15:0] t15, t16, t17;
  logic [19:0]        sqr16;
  logic [31:0]        nx16, prodx;
  logic [15:0]        x1_17;
  logic signed [15:0] x2_17;
  logic signed [19:0] sum, pf;

  assign ps = pside_t'(in_side[PSIDE_W-1:0]);

  always_comb begin
    p32   = ps.hi ? {div_q[30:0], 1'b0} : div_q[31:0];
    prodx = 32'(sqr16 * 12'd3038);
    sum   = $signed({4'd0, x1_17}) + {{4{x2_17[15]}}, x2_17} + 20'sd3791;
    pf    = $signed({2'd0, p17}) + {{4{sum[19]}}, sum[19:4]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p15   <= p32[17:0];
      big15 <= |p32[31:18];
      f15   <= ps.fault;
      t15   <= ps.t;

      sqr16 <= p15[17:8] * p15[17:8];
      nx16  <= 32'd0 - 32'(p15 * 13'd7357);
      p16 <= p15; big16 <= big15; f16 <= f15; t16 <= t15;

      x1_17 <= prodx[31:16];
      x2_17 <= nx16[31:16];
      p17 <= p16; big17 <= big16; f17 <= f16; t17 <= t16;

      div_fault <= f17;
      if (f17) begin
        temperature <= '0;
        pressure    <= '0;
      end else begin
        temperature <= t17;
        if (big17 || pf > $signed({2'd0, PRESS_MAX})) begin
          pressure <= PRESS_MAX;
        end else if (pf[19]) begin
          pressure <= '0;
        end else begin
          pressure <= pf[17:0];
        end
      end
    end
  end

endmodule

// ===== sv/barometric_pressure_compensation.sv =====
// Compensates one raw temperature word and one raw pressure word into
// temperature (0.1 degree units) and pressure (pascal) with the standard
// integer calibration formulas. One item is accepted every clock cycle
// unless the output is stalled; each item passes through the two 33-stage
// pipelined restoring dividers (temperature term, then pressure term) and
// 18 arithmetic stages. When the output is stalled the whole pipeline holds.
// Coefficients sit at byte offsets 0x00, 0x08, 0x10, 0x18 and the
// oversampling setting at 0x20; write them only while no item is in flight.
// A zero divisor sets div_fault and forces both results to zero, which is
// the case after reset until the coefficients are loaded.
module barometric_pressure_compensation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [15:0]                  raw_temp,
  input  logic [18:0]                  raw_pressure,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           temperature,
  output logic [17:0]                  pressure,
  output logic                         div_fault,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpc_pkg::DATA_W-1:0]   pwdata,
  output logic [bpc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bpc_pkg::*;

  logic [47:0]      signed_coeffs_a;
  logic [47:0]      unsigned_coeffs_a;
  logic [31:0]      signed_coeffs_b;
  logic [31:0]      temp_coeffs_m;
  logic [1:0]       oversampling;
  logic [IDX_W-1:0] reg_idx;
  logic             wr;
  logic             en;
  coef_t            coef;

  logic             td_valid, tq_valid, pd_valid, pq_valid;
  logic [DIV_W-1:0] td_dividend, tq, pd_dividend, pq;
  logic [DVS_W-1:0] td_divisor, pd_divisor;
  side_t            td_side, tq_side, pd_side, pq_side;

  assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_coeffs_a   <= '0;
      unsigned_coeffs_a <= '0;
      signed_coeffs_b   <= '0;
      temp_coeffs_m     <= '0;
      oversampling      <= 2'd3;
    end else if (wr) begin
      case (reg_idx)
        REG_SCA: signed_coeffs_a   <= pwdata[47:0];
        REG_UCA: unsigned_coeffs_a <= pwdata[47:0];
        REG_SCB: signed_coeffs_b   <= pwdata[31:0];
        REG_TCM: temp_coeffs_m     <= pwdata[31:0];
        REG_OSS: oversampling      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCA: prdata = {16'd0, signed_coeffs_a};
      REG_UCA: prdata = {16'd0, unsigned_coeffs_a};
      REG_SCB: prdata = {32'd0, signed_coeffs_b};
      REG_TCM: prdata = {32'd0, temp_coeffs_m};
      REG_OSS: prdata = {62'd0, oversampling};
      default: prdata = '0;
    endcase
  end

  assign coef.ac1 = signed_coeffs_a[47:32];
  assign coef.ac2 = signed_coeffs_a[31:16];
  assign coef.ac3 = signed_coeffs_a[15:0];
  assign coef.ac4 = unsigned_coeffs_a[47:32];
  assign coef.ac5 = unsigned_coeffs_a[31:16];
  assign coef.ac6 = unsigned_coeffs_a[15:0];
  assign coef.b1  = signed_coeffs_b[31:16];
  assign coef.b2  = signed_coeffs_b[15:0];
  assign coef.mc  = temp_coeffs_m[31:16];
  assign coef.md  = temp_coeffs_m[15:0];
  assign coef.oss = oversampling;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  bpc_tfront u_tfront (
    .clk, .rst, .en, .in_valid, .raw_temp, .raw_pressure, .coef,
    .div_valid(td_valid), .div_dividend(td_dividend),
    .div_divisor(td_divisor), .div_side(td_side)
  );

  bpc_div u_tdiv (
    .clk, .rst, .en, .in_valid(td_valid), .dividend(td_dividend),
    .divisor(td_divisor), .side_in(td_side),
    .out_valid(tq_valid), .quotient(tq), .side_out(tq_side)
  );

  bpc_pfront u_pfront (
    .clk, .rst, .en, .in_valid(tq_valid), .div_q(tq), .in_side(tq_side), .coef,
    .div_valid(pd_valid), .div_dividend(pd_dividend),
    .div_divisor(pd_divisor), .div_side(pd_side)
  );

  bpc_div u_pdiv (
    .clk, .rst, .en, .in_valid(pd_valid), .dividend(pd_dividend),
    .divisor(pd_divisor), .side_in(pd_side),
    .out_valid(pq_valid), .quotient(pq), .side_out(pq_side)
  );

  bpc_pback u_pback (
    .clk, .rst, .en, .in_valid(pq_valid), .div_q(pq), .in_side(pq_side),
    .out_valid, .temperature, .pressure, .div_fault
  );

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_fault |-> temperature == 16'sd0 && pressure == 18'd0)
    else $error("fault item with nonzero result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("item present after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while pipeline is frozen");

endmodule
